/* rtl/mlts_pkg.sv */
// Shared types, constants and the luminance function of the trail stacker.
package mlts_pkg;

  localparam int CFG_W   = 9;
  localparam int CH_W    = 8;
  localparam int LUMA_W  = 24;

  typedef logic [LUMA_W-1:0] luma_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  // Luminance weights, summing to 65536.
  localparam luma_t WEIGHT_R = luma_t'(13933);
  localparam luma_t WEIGHT_G = luma_t'(46871);
  localparam luma_t WEIGHT_B = luma_t'(4732);

  localparam cfg_data_t SIZE_RESET = cfg_data_t'(256);

  // Store word: red in the low byte, alpha in the high byte.
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // Position flags handed from the sequencer to the update stage.
  typedef struct packed {
    logic first;  // stack not started: store unconditionally
    logic last;   // last pixel of the frame
  } pos_info_t;

  function automatic luma_t luma(input pixel_t px);
    luma_t y;
    y = luma_t'(px.red) * WEIGHT_R
      + luma_t'(px.green) * WEIGHT_G
      + luma_t'(px.blue) * WEIGHT_B;
    return y;
  endfunction

endpackage

/* rtl/mlts_seq.sv */
// Frame sequencer: size registers, raster counters and store address.
module mlts_seq
  import mlts_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_index_t        cfg_index,
  input  cfg_data_t         cfg_data,
  input  logic              advance,
  output logic [ADDR_W-1:0] rd_addr,
  output pos_info_t         info
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  cfg_data_t         width_r, width_nxt;
  cfg_data_t         height_r, height_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              started_r, started_nxt;
  logic [XW-1:0]     x_last;
  logic [YW-1:0]     y_last;
  logic              at_line_end;
  logic              at_frame_end;

  // Clamp sizes to 1..max, expressed as the last index.
  always_comb begin
    if (width_r == '0) begin
      x_last = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      x_last = XW'(MAX_WIDTH - 1);
    end else begin
      x_last = XW'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      y_last = '0;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      y_last = YW'(MAX_HEIGHT - 1);
    end else begin
      y_last = YW'(height_r - 1'b1);
    end
  end

  assign at_line_end  = (x_r == x_last);
  assign at_frame_end = at_line_end && (y_r == y_last);

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
      // restart the stack
      x_nxt       = '0;
      y_nxt       = '0;
      pos_nxt     = '0;
      started_nxt = 1'b0;
    end else if (advance) begin
      if (at_frame_end) begin
        x_nxt       = '0;
        y_nxt       = '0;
        pos_nxt     = '0;
        started_nxt = 1'b1;
      end else if (at_line_end) begin
        x_nxt   = '0;
        y_nxt   = y_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
      end else begin
        x_nxt   = x_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SIZE_RESET;
      height_r  <= SIZE_RESET;
      x_r       <= '0;
      y_r       <= '0;
      pos_r     <= '0;
      started_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
    end
  end

  assign rd_addr    = pos_r;
  assign info.first = ~started_r;
  assign info.last  = at_frame_end;

endmodule

/* rtl/mlts_core.sv */
// Frame store with read-compare-write update stage and output register.
module mlts_core
  import mlts_pkg::*;
#(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pixel_t            in_px,
  input  logic [ADDR_W-1:0] rd_addr,
  input  pos_info_t         info,
  output logic              accept,
  output logic              out_valid,
  input  logic              out_ready,
  output pixel_t            out_px,
  output logic              out_replaced,
  output logic              out_frame_end
);

  pixel_t            mem [DEPTH];

  pixel_t            rd_data_r;
  logic              s1_valid_r, s1_valid_nxt;
  pixel_t            s1_px_r;
  luma_t             s1_luma_r;
  logic [ADDR_W-1:0] s1_addr_r;
  pos_info_t         s1_info_r;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  pixel_t            fwd_data_r;
  logic              out_valid_r, out_valid_nxt;
  pixel_t            out_px_r;
  logic              out_replaced_r;
  logic              out_frame_end_r;

  logic              s1_adv;
  logic              take;
  logic              wr_en;
  pixel_t            stored;
  pixel_t            kept;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Forward the write made on the edge this entry was read.
  assign stored = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rd_data_r;
  assign take   = s1_info_r.first || (s1_luma_r > luma(stored));
  assign kept   = take ? s1_px_r : stored;
  assign wr_en  = s1_adv && take;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[s1_addr_r] <= kept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_px;
      s1_luma_r <= luma(in_px);
      s1_addr_r <= rd_addr;
      s1_info_r <= info;
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= kept;
    end
    if (s1_adv) begin
      out_px_r        <= kept;
      out_replaced_r  <= take;
      out_frame_end_r <= s1_info_r.last;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_px        = out_px_r;
  assign out_replaced  = out_replaced_r;
  assign out_frame_end = out_frame_end_r;

endmodule

/* rtl/max_luminance_trail_stack.sv */
// Top level of the max-luminance trail stacker.
//
// Channel  | Ports                                   | Direction | Transfer when
// ---------+-----------------------------------------+-----------+----------------------
// input    | in_valid/in_ready, in_red..in_alpha     | in        | in_valid & in_ready
// result   | out_valid/out_ready, out_kept_*, flags  | out       | out_valid & out_ready
// config   | cfg_we, cfg_index, cfg_data             | in        | cfg_we
//
// One pixel per clock sustained while out_ready is held high. The store read is issued
// on the input transfer, then the update stage compares luminance and writes back on the
// same edge the result register loads. A write on that edge is forwarded to a read
// of the same entry.
// Reset (synchronous, rst_n low) clears control only; the store holds garbage
// until the first frame has written every entry it uses. No clearing pass is needed.
// A stalled result register holds the update stage, which in turn drops in_ready.
module max_luminance_trail_stack
  import mlts_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  // input pixels
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  // kept pixels
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_kept_red,
  output logic [7:0] out_kept_green,
  output logic [7:0] out_kept_blue,
  output logic [7:0] out_kept_alpha,
  output logic       out_replaced,
  output logic       out_frame_end
);

  // Store holds one word per raster position of the largest frame.
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0] rd_addr;
  pos_info_t         info;
  logic              accept;
  pixel_t            in_px;
  pixel_t            out_px;

  assign in_px.red   = in_red;
  assign in_px.green = in_green;
  assign in_px.blue  = in_blue;
  assign in_px.alpha = in_alpha;

  // Raster position advances on each input transfer; a config write restarts it and takes priority.
  mlts_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .rd_addr   (rd_addr),
    .info      (info)
  );

  // Read-modify-write of the store entry, then the result register.
  mlts_core #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_px         (in_px),
    .rd_addr       (rd_addr),
    .info          (info),
    .accept        (accept),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_px        (out_px),
    .out_replaced  (out_replaced),
    .out_frame_end (out_frame_end)
  );

  assign out_kept_red   = out_px.red;
  assign out_kept_green = out_px.green;
  assign out_kept_blue  = out_px.blue;
  assign out_kept_alpha = out_px.alpha;

endmodule

/* verif/tb_max_luminance_trail_stack.sv */
// Self-checking testbench of the max-luminance trail stacker.
`timescale 1ns / 100ps

module tb_max_luminance_trail_stack;
  import mlts_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int STORE_WORDS = 256 * 256;
  localparam int DIM_MAX = 256;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES = 300;
  // Luminance weights, fixed point over 65536.
  localparam int unsigned W_RED = 13933;
  localparam int unsigned W_GREEN = 46871;
  localparam int unsigned W_BLUE = 4732;

  typedef struct packed {
    pixel_t px;
    logic replaced;
    logic frame_end;
  } trail_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_FRAME_WIDTH;
  cfg_data_t cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_alpha = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_kept_red;
  logic [7:0] out_kept_green;
  logic [7:0] out_kept_blue;
  logic [7:0] out_kept_alpha;
  logic out_replaced;
  logic out_frame_end;

  // Pixels waiting for the driver, and kept pixels waiting for the DUT.
  pixel_t pix_queue[$];
  trail_result_t kept_q[$];

  // Predictor state: its own copy of the frame store and the size registers.
  pixel_t trail_mem[0:STORE_WORDS-1];
  int unsigned trail_pos = 0;
  bit trail_live = 1'b0;
  cfg_data_t reg_width = SIZE_RESET;
  cfg_data_t reg_height = SIZE_RESET;

  // Last pixel sent at each position, to build equal-luminance revisits.
  pixel_t sent_hist[0:STORE_WORDS-1];

  // Traffic control written by the stimulus process.
  bit calm = 1'b0;
  int hold_req = 0;

  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_replaced = 0;
  int n_frames = 0;
  int n_writes = 0;
  int n_in_stalls = 0;

  max_luminance_trail_stack u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kept_red   (out_kept_red),
    .out_kept_green (out_kept_green),
    .out_kept_blue  (out_kept_blue),
    .out_kept_alpha (out_kept_alpha),
    .out_replaced   (out_replaced),
    .out_frame_end  (out_frame_end)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Map a size register to the dimension in use: zero acts as one, and
  // anything past the maximum acts as the maximum.
  function automatic int unsigned clamp_dim(cfg_data_t v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned brightness(pixel_t p);
    return W_RED * p.red + W_GREEN * p.green + W_BLUE * p.blue;
  endfunction

  function automatic pixel_t mk_px(int r, int g, int b, int a);
    pixel_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  // Stack one pixel into the predicted store and return what the DUT must
  // report for it. Replace only on a strictly brighter pixel, except during
  // the first frame, which is stored as it comes.
  function automatic trail_result_t update_trail(pixel_t px);
    int unsigned area;
    int unsigned pos;
    trail_result_t r;
    area = clamp_dim(reg_width) * clamp_dim(reg_height);
    pos = (trail_pos >= area) ? 0 : trail_pos;
    r.replaced = !trail_live || brightness(px) > brightness(trail_mem[pos]);
    if (r.replaced) trail_mem[pos] = px;
    r.px = trail_mem[pos];
    r.frame_end = (pos + 1 >= area);
    if (r.frame_end) begin
      trail_pos = 0;
      trail_live = 1'b1;
    end else begin
      trail_pos = pos + 1;
    end
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Driver: offer pixels in bursts of random length separated by random
  // gaps; in calm mode offer back to back. Hold the payload while stalled.
  always @(posedge clk) begin : driver
    int burst_left;
    int gap_left;
    pixel_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 && !calm) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pix_queue.size() != 0) begin
        p = pix_queue.pop_front();
        in_red <= p.red;
        in_green <= p.green;
        in_blue <= p.blue;
        in_alpha <= p.alpha;
        in_valid <= 1'b1;
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a repeating pattern whose period and stall length
  // are redrawn every round; ready when calm; on request, hold off for a long stretch.
  always @(posedge clk) begin : receiver
    int rx_tick;
    int rx_period;
    int rx_stall;
    int hold_left;
    int hold_seen;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_tick = 0;
      rx_period = 8;
      rx_stall = 2;
      hold_left = 0;
      hold_seen = 0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= (rx_tick >= rx_stall);
      rx_tick++;
      if (rx_tick >= rx_period) begin
        rx_tick = 0;
        rx_period = $urandom_range(4, 16);
        rx_stall = $urandom_range(0, 3);
      end
    end
  end

  // Monitor: track register writes, predict on every input transfer and
  // compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : monitor
    trail_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        // Either register restarts the stack; the store keeps its contents.
        case (cfg_index)
          CFG_FRAME_WIDTH: reg_width = cfg_data;
          CFG_FRAME_HEIGHT: reg_height = cfg_data;
          default: ;
        endcase
        trail_pos = 0;
        trail_live = 1'b0;
      end
      if (in_valid && !in_ready) n_in_stalls++;
      if (in_valid && in_ready) begin
        want = update_trail(mk_px(in_red, in_green, in_blue, in_alpha));
        n_replaced += want.replaced;
        n_frames += want.frame_end;
        kept_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h", $time,
                   {out_kept_alpha, out_kept_blue, out_kept_green, out_kept_red});
          n_errors++;
        end else begin
          want = kept_q.pop_front();
          n_checked++;
          check_field("kept_red", want.px.red, out_kept_red);
          check_field("kept_green", want.px.green, out_kept_green);
          check_field("kept_blue", want.px.blue, out_kept_blue);
          check_field("kept_alpha", want.px.alpha, out_kept_alpha);
          check_field("replaced", want.replaced, out_replaced);
          check_field("frame_end", want.frame_end, out_frame_end);
        end
      end
    end
  end

  // Return at a clock edge once nothing is queued, offered or outstanding.
  task automatic wait_drained();
    @(posedge clk);
    while (pix_queue.size() != 0 || in_valid || kept_q.size() != 0) @(posedge clk);
  endtask

  // Write one register, then drop the enable.
  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  // Draw a pixel: mostly uniform, with dim, bright and single-channel
  // pixels, and revisits of an earlier pixel's color with a fresh alpha so
  // that equal luminance comes up often.
  function automatic pixel_t next_pixel(int unsigned pos, bit seen);
    pixel_t p;
    int sel;
    p = pixel_t'($urandom);
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        if (seen) begin
          p = sent_hist[pos];
          p.alpha = 8'($urandom_range(0, 255));
        end
      end
      2: begin
        p.red = 8'($urandom_range(0, 31));
        p.green = 8'($urandom_range(0, 31));
        p.blue = 8'($urandom_range(0, 31));
      end
      3: begin
        p.red = 8'($urandom_range(224, 255));
        p.green = 8'($urandom_range(224, 255));
        p.blue = 8'($urandom_range(224, 255));
      end
      4: begin
        p.red = 0;
        p.green = 0;
        p.blue = 0;
        case ($urandom_range(0, 2))
          0: p.red = 8'hff;
          1: p.green = 8'hff;
          default: p.blue = 8'hff;
        endcase
      end
      default: ;
    endcase
    return p;
  endfunction

  // Program a frame size, then stream n pixels of random content. Pause the
  // sender now and then until every kept pixel is back; on request hold off
  // the receiver while the sender keeps offering.
  task automatic run_stack(cfg_data_t w, cfg_data_t h, int n, bit smooth, bit long_hold);
    int unsigned area;
    int chunk;
    pixel_t p;
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    area = clamp_dim(w) * clamp_dim(h);
    chunk = $urandom_range(20, 120);
    calm <= smooth;
    if (long_hold) hold_req <= hold_req + 1;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i % chunk == 0 && $urandom_range(0, 2) == 0) wait_drained();
      p = next_pixel(i % area, i >= area);
      sent_hist[i % area] = p;
      pix_queue.push_back(p);
    end
  endtask

  initial begin : stimulus
    int n_random;
    int n_px;
    int unsigned w;
    int unsigned h;
    n_random = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 3x2 frame of extremes stored as is, then a frame that
    // tests strictly-brighter, equal luminance and alpha-only differences.
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 2);
    pix_queue.push_back(mk_px(0, 0, 0, 0));
    pix_queue.push_back(mk_px(255, 255, 255, 255));
    pix_queue.push_back(mk_px(255, 0, 0, 0));
    pix_queue.push_back(mk_px(0, 255, 0, 0));
    pix_queue.push_back(mk_px(0, 0, 255, 0));
    pix_queue.push_back(mk_px(0, 0, 0, 255));
    pix_queue.push_back(mk_px(1, 0, 0, 7));       // just brighter than black
    pix_queue.push_back(mk_px(255, 255, 255, 0)); // equal luma, alpha differs
    pix_queue.push_back(mk_px(0, 0, 255, 255));   // darker than red
    pix_queue.push_back(mk_px(255, 0, 255, 255)); // darker than green
    pix_queue.push_back(mk_px(0, 26, 0, 1));      // beats pure blue
    pix_queue.push_back(mk_px(0, 0, 0, 0));       // alpha only, no gain
    // Break off a third frame halfway and restart with a same-value write.
    pix_queue.push_back(mk_px(255, 255, 255, 255));
    pix_queue.push_back(mk_px(0, 0, 0, 0));
    pix_queue.push_back(mk_px(128, 128, 128, 128));
    wait_drained();
    write_reg(CFG_FRAME_HEIGHT, 2);
    for (int i = 0; i < 6; i++) pix_queue.push_back(mk_px(i, 0, 0, 255 - i));

    // Extremes: both registers at zero, the widest line, the tallest column
    // (height written out of range), the last two with a long receiver hold-off.
    run_stack(0, 0, 25, 1'b0, 1'b0);
    run_stack(256, 1, 300, 1'b0, 1'b1);
    run_stack(0, 511, 290, 1'b1, 1'b1);
    n_random = 615;

    // Small random sizes, several frames each, often cut off mid-frame.
    while (n_random < RANDOM_ITEMS) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      n_px = w * h * $urandom_range(2, 5) + $urandom_range(0, w * h - 1);
      run_stack(w, h, n_px, $urandom_range(0, 4) == 0, 1'b0);
      n_random += n_px;
    end

    wait_drained();
    // Give a stray result time to show up.
    repeat (20) @(posedge clk);
    $display("Stacked %0d pixels over %0d register writes: %0d replaced, %0d frame ends.",
             n_sent, n_writes, n_replaced, n_frames);
    $display("Checked %0d results; input held off for %0d cycles.", n_checked, n_in_stalls);
    if (n_errors == 0) begin
      $display("tb_max_luminance_trail_stack: PASS");
    end else begin
      $display("tb_max_luminance_trail_stack: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("tb_max_luminance_trail_stack: FAIL");
    $finish;
  end

endmodule
